@@ hdl/bfrz_pkg.sv @@
// Shared constants, types and the row expansion function for the font row zoom block.
package bfrz_pkg;

  localparam int RowBits  = 8;
  localparam int MaxZoom  = 8;
  localparam int LineBits = RowBits * MaxZoom;
  localparam int ZoomW    = 4;
  localparam int ZmW      = $clog2(MaxZoom);
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 4;

  localparam logic [ZoomW-1:0]   ZoomReset         = ZoomW'(2);
  localparam logic [CfgIdxW-1:0] CfgZoomFactor     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSourceLsbFirst = CfgIdxW'(1);

  // One expanded row waiting for output, handed from the row stage to the byte stage.
  typedef struct packed {
    logic                valid;
    logic [LineBits-1:0] line;   // bit p is scaled pixel p in output order
    logic [ZmW-1:0]      zm1;    // zoom minus one
    logic                eog;
  } row_line_t;

  // Zoom register to zoom minus one, saturated to 1..MaxZoom.
  function automatic logic [ZmW-1:0] zoom_minus_one(input logic [ZoomW-1:0] zf);
    logic [ZmW-1:0] r;
    if (zf == '0) begin
      r = '0;
    end else if (zf > ZoomW'(MaxZoom)) begin
      r = ZmW'(MaxZoom - 1);
    end else begin
      r = ZmW'(zf - ZoomW'(1));
    end
    return r;
  endfunction

  // Replicate each source pixel zm1+1 times along the scaled line.
  function automatic logic [LineBits-1:0] expand_row(input logic [RowBits-1:0] row,
                                                     input logic               lsb_first,
                                                     input logic [ZmW-1:0]     zm1);
    logic [LineBits-1:0] line;
    logic [RowBits-1:0]  pix;
    int                  zi;
    line = '0;
    zi   = int'(zm1) + 1;
    for (int i = 0; i < RowBits; i++) begin
      pix[i] = lsb_first ? row[i] : row[RowBits-1-i];
    end
    for (int i = 0; i < RowBits; i++) begin
      for (int j = 0; j < MaxZoom; j++) begin
        if (j < zi) begin
          line[($clog2(LineBits))'(i * zi + j)] = pix[i];
        end
      end
    end
    return line;
  endfunction

endpackage

@@ hdl/bfrz_row_stage.sv @@
// Input register: accepts a font row request and holds its expanded scaled line.
module bfrz_row_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bfrz_pkg::RowBits-1:0]   font_row_i,
  input  logic                           end_of_glyph_i,
  input  logic [bfrz_pkg::ZoomW-1:0]     zoom_factor_i,
  input  logic                           source_lsb_first_i,
  input  logic                           pop_i,
  output bfrz_pkg::row_line_t            row_o
);
  import bfrz_pkg::*;

  logic                valid_q;
  logic [LineBits-1:0] line_q;
  logic [ZmW-1:0]      zm1_q, zm1_d;
  logic                eog_q;
  logic                accept;

  // Free when empty or when the last byte of the held row leaves this cycle.
  assign in_stall_o = valid_q && !pop_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign zm1_d      = zoom_minus_one(zoom_factor_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= expand_row(font_row_i, source_lsb_first_i, zm1_d);
      zm1_q  <= zm1_d;
      eog_q  <= end_of_glyph_i;
    end
  end

  assign row_o.valid = valid_q;
  assign row_o.line  = line_q;
  assign row_o.zm1   = zm1_q;
  assign row_o.eog   = eog_q;

endmodule

@@ hdl/bfrz_byte_stage.sv @@
// Byte sequencer and output register: walks repeats and bytes of the held line.
module bfrz_byte_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfrz_pkg::row_line_t          row_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bfrz_pkg::RowBits-1:0] scaled_byte_o,
  output logic                         last_of_run_o,
  output logic                         glyph_done_o
);
  import bfrz_pkg::*;

  logic [ZmW-1:0]     k_q, a_q;
  logic               out_valid_q;
  logic [RowBits-1:0] byte_q, byte_d;
  logic               last_q, done_q;
  logic               load, last_k, last_a, last;

  assign load   = row_i.valid && (!out_valid_q || !out_stall_i);
  assign last_k = (k_q == row_i.zm1);
  assign last_a = (a_q == row_i.zm1);
  assign last   = last_k && last_a;
  assign pop_o  = load && last;

  // Byte k covers line positions 8k..8k+7, first one into bit 7.
  always_comb begin
    for (int b = 0; b < RowBits; b++) begin
      byte_d[RowBits-1-b] = row_i.line[{k_q, 3'(b)}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      a_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (last_k) begin
          k_q <= '0;
          a_q <= last_a ? '0 : a_q + ZmW'(1);
        end else begin
          k_q <= k_q + ZmW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last;
      done_q <= last && row_i.eog;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scaled_byte_o = byte_q;
  assign last_of_run_o = last_q;
  assign glyph_done_o  = done_q;

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q)
    else $error("glyph_done without last_of_run");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_i.valid |-> (k_q <= row_i.zm1) && (a_q <= row_i.zm1))
    else $error("byte counters beyond zoom");

  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == '0) && (a_q == '0))
    else $error("counters not rewound after run");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded byte not presented");

endmodule

@@ hdl/bitmap_font_row_zoom_core.sv @@
// Top level of the font row zoom block: config registers and the two stages.
//
// Input channel (in_valid_i / in_stall_o) takes one 8-pixel glyph row with an
// end-of-glyph flag. Output channel (out_valid_o / out_stall_i) gives zoom*zoom
// bytes per row, MSB first; last_of_run_o marks the final byte of a row and
// glyph_done_o additionally marks it when the row ended a glyph.
// Config port: cfg_valid_i with cfg_ready_o tied high; index 0 is zoom_factor
// (saturated to 1..8), index 1 is source_lsb_first. Write only while idle.
// Path: the first byte of a row passes the row register, then the output register.
// Throughput: one output byte per cycle while out_stall_i is low; the output
// register is the limiting port. The next row is taken in the cycle the previous
// row's last byte is loaded, so rows follow without gaps. When out_stall_i is
// high while a byte is presented, the output byte holds, the sequencer pauses,
// and in_stall_o rises once the row register is full.
// Reset clears all valids and counters, zoom to 2 and MSB-first reading.
module bitmap_font_row_zoom_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bfrz_pkg::RowBits-1:0]  font_row_i,
  input  logic                          end_of_glyph_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bfrz_pkg::RowBits-1:0]  scaled_byte_o,
  output logic                          last_of_run_o,
  output logic                          glyph_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfrz_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bfrz_pkg::CfgDataW-1:0] cfg_data_i
);
  import bfrz_pkg::*;

  logic [ZoomW-1:0] zoom_factor_q;
  logic             source_lsb_first_q;
  row_line_t        row;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_factor_q      <= ZoomReset;
      source_lsb_first_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgZoomFactor:     zoom_factor_q      <= cfg_data_i[ZoomW-1:0];
        CfgSourceLsbFirst: source_lsb_first_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bfrz_row_stage u_row_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .font_row_i         (font_row_i),
    .end_of_glyph_i     (end_of_glyph_i),
    .zoom_factor_i      (zoom_factor_q),
    .source_lsb_first_i (source_lsb_first_q),
    .pop_i              (pop),
    .row_o              (row)
  );

  bfrz_byte_stage u_byte_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_i         (row),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scaled_byte_o (scaled_byte_o),
    .last_of_run_o (last_of_run_o),
    .glyph_done_o  (glyph_done_o)
  );

endmodule
